// ===== rtl/core/rttp_pkg.sv =====
// ============================================================================
// rttp_pkg
// Shared types, constants and the palette remap for the raster-to-tile
// 4bpp packer.
// ============================================================================
package rttp_pkg;

  // Default band capacity in 8-pixel cells.
  localparam int MAX_WIDTH_CELLS_DEF = 64;

  // Width of the width_cells register and its reset value.
  localparam int WCFG_W = 7;
  localparam logic [WCFG_W-1:0] WIDTH_CELLS_RST = 7'd40;

  // Last row of a band.
  localparam logic [2:0] LAST_ROW = 3'd7;

  // Operation codes of an input item.
  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_READ = 1'b1
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_VALID    = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // Result control that travels from the control unit to the output stage.
  typedef struct packed {
    status_t status;
    logic    last;
  } res_t;

  // Fixed 16-entry palette remap.
  function automatic logic [3:0] remap(input logic [3:0] idx);
    logic [3:0] r;
    case (idx)
      4'd0:    r = 4'd0;
      4'd1:    r = 4'd15;
      4'd2:    r = 4'd4;
      4'd3:    r = 4'd12;
      4'd4:    r = 4'd5;
      4'd5:    r = 4'd10;
      4'd6:    r = 4'd1;
      4'd7:    r = 4'd13;
      4'd8:    r = 4'd6;
      4'd9:    r = 4'd2;
      4'd10:   r = 4'd9;
      4'd11:   r = 4'd3;
      4'd12:   r = 4'd7;
      4'd13:   r = 4'd14;
      4'd14:   r = 4'd8;
      4'd15:   r = 4'd11;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/rttp_band_mem.sv =====
// ============================================================================
// rttp_band_mem
// Band memory: one write port and one read port, read data registered.
// ============================================================================
module rttp_band_mem import rttp_pkg::*; #(
  parameter int MAX_WIDTH_CELLS = MAX_WIDTH_CELLS_DEF,
  parameter int AW = $clog2(MAX_WIDTH_CELLS * 32)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  localparam int DEPTH = MAX_WIDTH_CELLS * 32;

  logic [7:0] mem_r [DEPTH];
  logic [7:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/rttp_ctrl.sv =====
// ============================================================================
// rttp_ctrl
// Fill and drain control: tracks the write column and row, the band-ready
// flag and the read pointer, and issues band memory accesses.
// ============================================================================
module rttp_ctrl import rttp_pkg::*; #(
  parameter int MAX_WIDTH_CELLS = MAX_WIDTH_CELLS_DEF,
  parameter int AW = $clog2(MAX_WIDTH_CELLS * 32)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  op_t               op,
  input  logic [3:0]        left_pixel,
  input  logic [3:0]        right_pixel,
  input  logic              cfg_we,
  input  logic [WCFG_W-1:0] cfg_wdata,
  output logic              wr_en,
  output logic [AW-1:0]     wr_addr,
  output logic [7:0]        wr_data,
  output logic              rd_en,
  output logic [AW-1:0]     rd_addr,
  output res_t              res
);

  localparam int MAXW_BITS = $clog2(MAX_WIDTH_CELLS + 1);
  localparam int CW  = (MAXW_BITS > WCFG_W) ? MAXW_BITS : WCFG_W;
  localparam int PCW = $clog2(MAX_WIDTH_CELLS * 4);
  localparam logic [CW-1:0] MAXW = CW'(MAX_WIDTH_CELLS);

  logic [WCFG_W-1:0] width_r;
  logic [PCW-1:0]    pair_col_r, pair_col_nxt;
  logic [2:0]        band_row_r, band_row_nxt;
  logic              band_ready_r, band_ready_nxt;
  logic [AW-1:0]     rd_ptr_r, rd_ptr_nxt;

  logic [CW-1:0]     eff_w;
  logic [CW-1:0]     w_ext;
  logic              line_end;
  logic              band_end;

  // Width register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= WIDTH_CELLS_RST;
    end else if (cfg_we) begin
      width_r <= cfg_wdata;
    end
  end

  // Effective width: zero acts as one, clamped to the band capacity.
  assign w_ext = CW'(width_r);
  always_comb begin
    if (w_ext == '0) begin
      eff_w = CW'(1);
    end else if (w_ext > MAXW) begin
      eff_w = MAXW;
    end else begin
      eff_w = w_ext;
    end
  end

  // End of line and end of band tests; four pairs and 32 bytes per cell.
  assign line_end = ((CW+3)'(pair_col_r) + (CW+3)'(1)) >= ((CW+3)'(eff_w) << 2);
  assign band_end = ((CW+6)'(rd_ptr_r) + (CW+6)'(1)) >= ((CW+6)'(eff_w) << 5);

  // Tile address of the current pair: cell * 32 + row * 4 + pair in cell.
  assign wr_addr = (AW'(pair_col_r >> 2) << 5) | (AW'(band_row_r) << 2)
                 | AW'(pair_col_r[1:0]);
  assign wr_data = {remap(left_pixel), remap(right_pixel)};
  assign wr_en   = accept && (op == OP_PUSH) && !band_ready_r;

  assign rd_addr = rd_ptr_r;
  assign rd_en   = accept && (op == OP_READ) && band_ready_r;

  // Result status and next state.
  always_comb begin
    pair_col_nxt   = pair_col_r;
    band_row_nxt   = band_row_r;
    band_ready_nxt = band_ready_r;
    rd_ptr_nxt     = rd_ptr_r;
    res.last       = 1'b0;
    if (op == OP_PUSH) begin
      res.status = band_ready_r ? ST_FULL : ST_ACCEPTED;
      if (!band_ready_r) begin
        if (line_end) begin
          pair_col_nxt = '0;
          band_row_nxt = band_row_r + 3'd1;
          if (band_row_r == LAST_ROW) begin
            band_ready_nxt = 1'b1;
            rd_ptr_nxt     = '0;
          end
        end else begin
          pair_col_nxt = pair_col_r + PCW'(1);
        end
      end
    end else begin
      res.status = band_ready_r ? ST_VALID : ST_EMPTY;
      if (band_ready_r) begin
        if (band_end) begin
          res.last       = 1'b1;
          band_ready_nxt = 1'b0;
          rd_ptr_nxt     = '0;
        end else begin
          rd_ptr_nxt = rd_ptr_r + AW'(1);
        end
      end
    end
  end

  // State registers advance only on an accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_col_r   <= '0;
      band_row_r   <= '0;
      band_ready_r <= 1'b0;
      rd_ptr_r     <= '0;
    end else if (accept) begin
      pair_col_r   <= pair_col_nxt;
      band_row_r   <= band_row_nxt;
      band_ready_r <= band_ready_nxt;
      rd_ptr_r     <= rd_ptr_nxt;
    end
  end

endmodule

// ===== rtl/core/raster_to_tile_4bpp_packer_top.sv =====
// ============================================================================
// raster_to_tile_4bpp_packer_top
// Packs raster pixel pairs into 8x8 4bpp tile bytes in a band memory and
// streams a finished band back out in address order.
// ============================================================================
//
//   Channel   Signals                                        Direction
//   -------   --------------------------------------------   ---------
//   input     in_valid, in_stall, in_operation,              in
//             in_left_pixel, in_right_pixel
//   result    out_valid, out_stall, out_data_byte,           out
//             out_status, out_band_last
//   config    cfg_we, cfg_wdata (width_cells)                in
//
// One item is accepted per cycle while in_stall is low; each result is
// registered in the memory stage with the band memory read, then in the
// output register. The single-port-per-direction band memory sets this
// rate: each item makes at most one write or one read.
// Reset is synchronous; the band memory is not cleared.
// A stalled output holds the pipeline; in_stall rises only when both the
// memory stage and the output register are occupied.
// ============================================================================
module raster_to_tile_4bpp_packer_top import rttp_pkg::*; #(
  parameter int MAX_WIDTH_CELLS = MAX_WIDTH_CELLS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_operation,
  input  logic [3:0]        in_left_pixel,
  input  logic [3:0]        in_right_pixel,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_data_byte,
  output logic [1:0]        out_status,
  output logic              out_band_last,
  input  logic              cfg_we,
  input  logic [WCFG_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(MAX_WIDTH_CELLS * 32);

  logic          accept;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  res_t          res;

  logic          s1_valid_r;
  res_t          s1_res_r;
  logic          out_valid_r;
  logic [7:0]    out_data_r;
  res_t          out_res_r;
  logic          out_load;

  // Handshake: the memory stage moves when the output register frees up.
  assign out_load = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !out_load;
  assign accept   = in_valid && !in_stall;

  rttp_ctrl #(
    .MAX_WIDTH_CELLS(MAX_WIDTH_CELLS),
    .AW(AW)
  ) u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .accept(accept),
    .op(op_t'(in_operation)),
    .left_pixel(in_left_pixel),
    .right_pixel(in_right_pixel),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .res(res)
  );

  // Reads and writes of one band never meet in one cycle, so the memory
  // needs no forwarding.
  rttp_band_mem #(
    .MAX_WIDTH_CELLS(MAX_WIDTH_CELLS),
    .AW(AW)
  ) u_mem (
    .clk(clk),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Memory stage: result control waits here beside the read in flight.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res_r <= res;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_valid_r) begin
      out_res_r  <= s1_res_r;
      out_data_r <= (s1_res_r.status == ST_VALID) ? rd_data : 8'd0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data_byte = out_data_r;
  assign out_status    = out_res_r.status;
  assign out_band_last = out_res_r.last;

  // The input stalls only when the memory stage is occupied.
  a_stall_needs_s1 : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with empty memory stage");

  // An accepted item always lands in the memory stage.
  a_accept_fills_s1 : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_valid_r)
    else $error("accepted item lost");

  // The band end mark only comes with a valid byte.
  a_last_is_valid : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.last) |-> (out_res_r.status == ST_VALID))
    else $error("band end marked on a non-read result");

  // Non-read results carry a zero byte.
  a_zero_data : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_res_r.status != ST_VALID)) |-> (out_data_r == 8'd0))
    else $error("nonzero byte on a non-read result");

endmodule
